[rtl/fbg_pkg.sv]
package fbg_pkg;

  localparam int ValueW = 64;
  localparam int FracW  = 52;
  localparam int ExpW   = 11;
  localparam int DigitW = 10;
  localparam int CfgIdxW = 2;
  localparam int CfgDataW = 10;

  localparam logic [CfgIdxW-1:0] CfgAction    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgDigitKind = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgDigits    = 2'd2;

  localparam logic [1:0] ActTrim = 2'd0;
  localparam logic [1:0] ActPad  = 2'd1;

  localparam logic [DigitW-1:0] DigitsReset = 10'd3;

  // powers of ten 10^PowMin .. 10^PowMax, one entry each
  localparam int PowMin = -323;
  localparam int PowMax = 308;
  localparam int PowCnt = PowMax - PowMin + 1;
  localparam int RomAw  = 10;
  localparam int BinW   = 12;
  localparam int SigW   = 54;
  localparam int EntW   = BinW + SigW;
  localparam int TabW   = PowCnt * EntW;
  localparam int BigW   = 768;

  localparam int ChunkW = 13;
  localparam int Chunks = 4;

  typedef struct packed {
    logic signed [BinW-1:0] binade;
    logic [SigW-1:0]        sig_ceil;
  } pow10_ent_t;

  typedef struct packed {
    logic [Chunks-1:0]      nz;
    logic [Chunks-1:0][3:0] cnt;
  } lzc_t;

  typedef struct packed {
    logic signed [BinW-1:0]   binade;
    logic [FracW:0]           sig;
    logic signed [RomAw-1:0]  pow;
    logic [RomAw-1:0]         addr;
  } dec_t;

  function automatic logic [5:0] kept_bits(input logic [4:0] n);
    logic [5:0] b;
    case (n)
      5'd1:  b = 6'd4;
      5'd2:  b = 6'd7;
      5'd3:  b = 6'd10;
      5'd4:  b = 6'd14;
      5'd5:  b = 6'd17;
      5'd6:  b = 6'd20;
      5'd7:  b = 6'd24;
      5'd8:  b = 6'd27;
      5'd9:  b = 6'd30;
      5'd10: b = 6'd34;
      5'd11: b = 6'd37;
      5'd12: b = 6'd40;
      5'd13: b = 6'd44;
      5'd14: b = 6'd47;
      5'd15: b = 6'd50;
      5'd16: b = 6'd52;
      default: b = 6'd0;
    endcase
    return b;
  endfunction

  // binade and rounded-up 53-bit significand of every power of ten in range
  function automatic logic [TabW-1:0] build_pow10_tab();
    logic [TabW-1:0] tab;
    logic [BigW-1:0] d;
    logic [BigW-1:0] r;
    logic [SigW-1:0] c;
    logic            sticky;
    int              len;
    int              q;
    int              i;
    tab = '0;
    d = BigW'(1);
    len = 1;
    for (q = 0; q <= -PowMin; q++) begin
      if (q <= PowMax) begin
        if (len <= 53) begin
          c = SigW'(d << (53 - len));
        end else begin
          c = SigW'(d >> (len - 53));
          sticky = |(d & ((BigW'(1) << (len - 53)) - BigW'(1)));
          c = c + SigW'(sticky);
        end
        tab[(q - PowMin) * EntW +: EntW] = {BinW'(q + len - 1), c};
      end
      if (q >= 1) begin
        r = (BigW'(1) << len) - d;
        c = SigW'(1);
        for (i = 0; i < 52; i++) begin
          r = r << 1;
          c = c << 1;
          if (r >= d) begin
            r = r - d;
            c[0] = 1'b1;
          end
        end
        c = c + SigW'(1);
        tab[(-q - PowMin) * EntW +: EntW] = {BinW'(-q - len), c};
      end
      d = (d << 2) + d;
      if (d[len + 2]) begin
        len = len + 3;
      end else begin
        len = len + 2;
      end
    end
    return tab;
  endfunction

endpackage

[rtl/fbg_in_if.sv]
interface fbg_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] value_bits;
  logic        last;

  modport source (output valid, output value_bits, output last, input ready);
  modport sink (input valid, input value_bits, input last, output ready);
endinterface

[rtl/fbg_out_if.sv]
interface fbg_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_bits;
  logic        last_out;

  modport source (output valid, output result_bits, output last_out, input ready);
  modport sink (input valid, input result_bits, input last_out, output ready);
endinterface

[rtl/fbg_lzc.sv]
module fbg_lzc (
  input  logic [fbg_pkg::FracW-1:0] frac,
  output fbg_pkg::lzc_t             lzc
);

  logic [fbg_pkg::ChunkW-1:0] chunk;

  always_comb begin
    lzc = '0;
    chunk = '0;
    for (int j = 0; j < fbg_pkg::Chunks; j++) begin
      chunk = frac[fbg_pkg::FracW-1-fbg_pkg::ChunkW*j -: fbg_pkg::ChunkW];
      lzc.nz[j] = |chunk;
      for (int i = 0; i < fbg_pkg::ChunkW; i++) begin
        if (chunk[i]) begin
          lzc.cnt[j] = 4'(fbg_pkg::ChunkW - 1 - i);
        end
      end
    end
  end

endmodule

[rtl/fbg_decode.sv]
module fbg_decode (
  input  logic [fbg_pkg::ValueW-1:0] value,
  input  fbg_pkg::lzc_t              lzc,
  output fbg_pkg::dec_t              dec
);

  logic [fbg_pkg::ExpW-1:0]     expo;
  logic [fbg_pkg::FracW-1:0]    frac;
  logic [5:0]                   lz;
  logic signed [29:0]           prod;
  logic signed [fbg_pkg::BinW-1:0] e_est;

  assign expo = value[62:52];
  assign frac = value[fbg_pkg::FracW-1:0];

  always_comb begin
    lz = '0;
    for (int j = fbg_pkg::Chunks - 1; j >= 0; j--) begin
      if (lzc.nz[j]) begin
        lz = 6'(fbg_pkg::ChunkW * j) + 6'(lzc.cnt[j]);
      end
    end
  end

  always_comb begin
    if (expo != '0) begin
      dec.binade = $signed({1'b0, expo}) - 12'sd1023;
      dec.sig    = {1'b1, frac};
    end else begin
      dec.binade = -12'sd1023 - $signed({6'd0, lz});
      dec.sig    = {1'b0, frac} << (lz + 6'd1);
    end
    prod     = dec.binade * $signed(18'sd78913);
    e_est    = prod[29:18];
    dec.pow  = 10'(e_est + 12'sd1);
    dec.addr = dec.pow + 10'd323;
  end

endmodule

[rtl/fbg_pow10_rom.sv]
module fbg_pow10_rom (
  input  logic                       clk,
  input  logic                       en,
  input  logic [fbg_pkg::RomAw-1:0]  addr,
  output fbg_pkg::pow10_ent_t        ent_r
);

  localparam logic [fbg_pkg::TabW-1:0] Tab = fbg_pkg::build_pow10_tab();

  always_ff @(posedge clk) begin
    if (en) begin
      ent_r <= Tab[int'(addr) * fbg_pkg::EntW +: fbg_pkg::EntW];
    end
  end

endmodule

[rtl/fbg_mask_gen.sv]
module fbg_mask_gen (
  input  logic [fbg_pkg::ValueW-1:0]        value,
  input  logic                              pad,
  input  fbg_pkg::dec_t                     dec,
  input  fbg_pkg::pow10_ent_t               ent,
  input  logic                              digit_kind,
  input  logic signed [fbg_pkg::DigitW-1:0] digits,
  output logic [fbg_pkg::ValueW-1:0]        result
);

  logic                              special;
  logic                              ge;
  logic signed [fbg_pkg::RomAw-1:0]  flog;
  logic signed [fbg_pkg::RomAw-1:0]  k;
  logic signed [11:0]                n_raw;
  logic [4:0]                        n;
  logic [5:0]                        kept;
  logic [fbg_pkg::ValueW-1:0]        mask;

  always_comb begin
    special = (value[62:0] == '0) || (value[62:52] == '1);
    ge      = (dec.binade == ent.binade) && ({1'b0, dec.sig} >= ent.sig_ceil);
    flog    = ge ? dec.pow : dec.pow - 10'sd1;
    k       = (flog >= -10'sd1) ? flog + 10'sd1 : flog + 10'sd2;
    n_raw   = 12'(digits) + (digit_kind ? 12'(k) : 12'sd0);
    if (n_raw < 12'sd1) begin
      n = 5'd1;
    end else if (n_raw > 12'sd16) begin
      n = 5'd16;
    end else begin
      n = n_raw[4:0];
    end
    kept = fbg_pkg::kept_bits(n);
    mask = {fbg_pkg::ValueW{1'b1}} << (6'd52 - kept);
    if (special) begin
      result = value;
    end else if (pad) begin
      result = value | ~mask;
    end else begin
      result = value & mask;
    end
  end

endmodule

[rtl/float64_bit_groomer_top.sv]
// Channel  Dir  Payload                      Request moves on
// in_ch    in   value_bits[63:0], last       valid & ready
// out_ch   out  result_bits[63:0], last_out  valid & ready
// cfg      in   cfg_index[1:0], cfg_wdata    cfg_we
//
// One request per cycle unless out_ch.ready stalls it; input register, lzc and decode/table stages, output register.
// The power-of-ten table read sits between the decode and mask stages.
// Synchronous active-low reset clears valids, position parity and configuration registers.
// Each stage holds only while full and blocked, so bubbles fill during stalls.
module float64_bit_groomer_top (
  input  logic                         clk,
  input  logic                         rst_n,
  fbg_in_if.sink                       in_ch,
  fbg_out_if.source                    out_ch,
  input  logic                         cfg_we,
  input  logic [fbg_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [fbg_pkg::CfgDataW-1:0] cfg_wdata
);

  logic [1:0]                        action_r;
  logic                              digit_kind_r;
  logic signed [fbg_pkg::DigitW-1:0] digits_r;
  logic                              odd_position_r;

  logic                              v0_r, v1_r, v2_r, out_valid_r;
  logic                              rdy0, rdy1, rdy2, rdy_o;
  logic [fbg_pkg::ValueW-1:0]        value0_r, value1_r, value2_r;
  logic                              last0_r, last1_r, last2_r;
  logic                              pad0_r, pad1_r, pad2_r;
  logic                              pad_nxt;
  fbg_pkg::lzc_t                     lzc_nxt, lzc1_r;
  fbg_pkg::dec_t                     dec_nxt, dec2_r;
  fbg_pkg::pow10_ent_t               ent2_r;
  logic [fbg_pkg::ValueW-1:0]        result_nxt, result_r;
  logic                              last_r;

  assign rdy_o = !out_valid_r || out_ch.ready;
  assign rdy2  = !v2_r || rdy_o;
  assign rdy1  = !v1_r || rdy2;
  assign rdy0  = !v0_r || rdy1;

  assign in_ch.ready        = rdy0;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.result_bits = result_r;
  assign out_ch.last_out    = last_r;

  always_comb begin
    if (action_r == fbg_pkg::ActTrim) begin
      pad_nxt = 1'b0;
    end else if (action_r == fbg_pkg::ActPad) begin
      pad_nxt = 1'b1;
    end else begin
      pad_nxt = odd_position_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      action_r     <= fbg_pkg::ActTrim;
      digit_kind_r <= 1'b0;
      digits_r     <= fbg_pkg::DigitsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        fbg_pkg::CfgAction:    action_r     <= cfg_wdata[1:0];
        fbg_pkg::CfgDigitKind: digit_kind_r <= cfg_wdata[0];
        fbg_pkg::CfgDigits:    digits_r     <= cfg_wdata[fbg_pkg::DigitW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      odd_position_r <= 1'b0;
      v0_r           <= 1'b0;
      v1_r           <= 1'b0;
      v2_r           <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (in_ch.valid && rdy0) begin
        odd_position_r <= in_ch.last ? 1'b0 : !odd_position_r;
      end
      if (rdy0) v0_r <= in_ch.valid;
      if (rdy1) v1_r <= v0_r;
      if (rdy2) v2_r <= v1_r;
      if (rdy_o) out_valid_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      value0_r <= in_ch.value_bits;
      last0_r  <= in_ch.last;
      pad0_r   <= pad_nxt;
    end
    if (rdy1) begin
      value1_r <= value0_r;
      last1_r  <= last0_r;
      pad1_r   <= pad0_r;
      lzc1_r   <= lzc_nxt;
    end
    if (rdy2) begin
      value2_r <= value1_r;
      last2_r  <= last1_r;
      pad2_r   <= pad1_r;
      dec2_r   <= dec_nxt;
    end
    if (rdy_o) begin
      result_r <= result_nxt;
      last_r   <= last2_r;
    end
  end

  fbg_lzc u_lzc (
    .frac (value0_r[fbg_pkg::FracW-1:0]),
    .lzc  (lzc_nxt)
  );

  fbg_decode u_decode (
    .value (value1_r),
    .lzc   (lzc1_r),
    .dec   (dec_nxt)
  );

  fbg_pow10_rom u_rom (
    .clk   (clk),
    .en    (rdy2),
    .addr  (dec_nxt.addr),
    .ent_r (ent2_r)
  );

  fbg_mask_gen u_mask (
    .value      (value2_r),
    .pad        (pad2_r),
    .dec        (dec2_r),
    .ent        (ent2_r),
    .digit_kind (digit_kind_r),
    .digits     (digits_r),
    .result     (result_nxt)
  );

endmodule

[test/tb_float64_bit_groomer_top.sv]
`timescale 1ns / 1ps

module tb_float64_bit_groomer_top;

  localparam logic [1:0] ActGroom = 2'd2;
  localparam int WideW    = 1536;
  localparam int Pow5Top  = 340;
  localparam int CycLimit = 400000;
  localparam int HoldCyc  = 300;
  localparam int SettleCyc = 8;

  typedef struct packed {
    logic [63:0] bits;
    logic        last;
  } elem_t;

  typedef enum logic [1:0] {RxOpen, RxHalf, RxSparse, RxMostly} rx_mode_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [fbg_pkg::CfgIdxW-1:0] cfg_index;
  logic [fbg_pkg::CfgDataW-1:0] cfg_wdata;

  fbg_in_if in_if ();
  fbg_out_if out_if ();

  float64_bit_groomer_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [WideW-1:0] pow5_tab [0:Pow5Top];

  elem_t elem_q [$];
  elem_t groomed_q [$];

  logic [1:0] act_m;
  logic kind_m;
  logic [fbg_pkg::DigitW-1:0] dig_m;

  elem_t nxt;
  elem_t want;
  int burst_left;
  int gap_left;
  logic odd_pos;
  int acc_cnt;
  int err_cnt;
  int cyc;
  rx_mode_t rx_mode;
  int mode_left;
  logic rdy;
  logic hold_off;
  int hold_left;
  logic hold_done;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // m * 2^q >= 10^e, exact
  function automatic logic ge_pow10(input logic [63:0] m, input int q, input int e);
    logic [WideW-1:0] lhs;
    logic [WideW-1:0] rhs;
    int s;
    lhs = '0;
    lhs[63:0] = m;
    rhs = '0;
    rhs[0] = 1'b1;
    if (e >= 0) begin
      rhs = pow5_tab[e];
    end else begin
      lhs = lhs * pow5_tab[-e];
    end
    s = q - e;
    if (s >= 0) begin
      lhs = lhs << s;
    end else begin
      rhs = rhs << (-s);
    end
    return lhs >= rhs;
  endfunction

  function automatic int floor_log10(input logic [63:0] m, input int q);
    int len;
    int e;
    int n;
    longint t;
    logic [63:0] v;
    len = 0;
    v = m;
    while (v != 0) begin
      len++;
      v = v >> 1;
    end
    t = longint'(q + len - 1) * 78913;
    e = int'(t >>> 18);
    n = 0;
    while (n < 4 && ge_pow10(m, q, e + 1)) begin
      e++;
      n++;
    end
    n = 0;
    while (n < 4 && !ge_pow10(m, q, e)) begin
      e--;
      n++;
    end
    return e;
  endfunction

  function automatic logic [63:0] groom_value(input logic [63:0] x, input logic [1:0] act,
                                              input logic dec,
                                              input logic [fbg_pkg::DigitW-1:0] dig,
                                              input logic odd);
    logic [fbg_pkg::ExpW-1:0] ex;
    logic [63:0] m;
    logic [63:0] mask;
    logic pad;
    int q;
    int f;
    int n;
    int kept;
    ex = x[62:52];
    if (x[62:0] == '0 || ex == '1) return x;
    n = $signed(dig);
    if (dec) begin
      m = '0;
      m[fbg_pkg::FracW-1:0] = x[fbg_pkg::FracW-1:0];
      if (ex != '0) begin
        m[fbg_pkg::FracW] = 1'b1;
        q = int'(ex) - 1075;
      end else begin
        q = -1074;
      end
      f = floor_log10(m, q);
      n = n + ((f >= -1) ? f + 1 : f + 2);
    end
    if (n < 1) n = 1;
    if (n > 16) n = 16;
    kept = (n * 33219 + 9999) / 10000;
    if (kept > fbg_pkg::FracW) kept = fbg_pkg::FracW;
    mask = ~64'd0 << (fbg_pkg::FracW - kept);
    case (act)
      fbg_pkg::ActTrim: pad = 1'b0;
      fbg_pkg::ActPad:  pad = 1'b1;
      default: pad = odd;
    endcase
    return pad ? (x | ~mask) : (x & mask);
  endfunction

  function automatic elem_t rand_elem();
    elem_t r;
    logic [63:0] b;
    int pick;
    int e;
    pick = $urandom_range(0, 99);
    b = {$urandom, $urandom};
    if (pick < 6) begin
      case ($urandom_range(0, 2))
        0: b = {b[63], 63'd0};
        1: b = {b[63], 11'h7ff, 52'd0};
        default: b = {b[63], 11'h7ff, b[51:1], 1'b1};
      endcase
    end else if (pick < 16) begin
      b[62:52] = '0;
    end else if (pick < 40) begin
      e = $urandom_range(0, 631);
      e = e - 323;
      b = $realtobits(10.0 ** e);
      b = b + $urandom_range(0, 6) - 3;
      b[63] = 1'($urandom_range(0, 1));
    end else if (pick < 60) begin
      b[62:52] = 11'(1023 + $urandom_range(0, 80) - 40);
    end
    r.bits = b;
    r.last = ($urandom_range(0, 5) == 0);
    return r;
  endfunction

  task automatic push_item(input logic [63:0] bits, input logic last);
    elem_q.push_back({bits, last});
  endtask

  task automatic write_reg(input logic [fbg_pkg::CfgIdxW-1:0] idx, input int val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[fbg_pkg::CfgDataW-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    while (elem_q.size() != 0 || in_if.valid || groomed_q.size() != 0) @(negedge clk);
    repeat (SettleCyc) @(posedge clk);
  endtask

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] exp_v);
    if (err_cnt < 40) $display("ERROR cycle %0d: %s got %h want %h", cyc, what, got, exp_v);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      act_m <= fbg_pkg::ActTrim;
      kind_m <= 1'b0;
      dig_m <= fbg_pkg::DigitsReset;
    end else if (cfg_we) begin
      case (cfg_index)
        fbg_pkg::CfgAction:    act_m <= cfg_wdata[1:0];
        fbg_pkg::CfgDigitKind: kind_m <= cfg_wdata[0];
        fbg_pkg::CfgDigits:    dig_m <= cfg_wdata[fbg_pkg::DigitW-1:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      in_if.value_bits <= '0;
      in_if.last <= 1'b0;
      odd_pos = 1'b0;
      burst_left = 0;
      gap_left = 0;
      acc_cnt = 0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        groomed_q.push_back({groom_value(in_if.value_bits, act_m, kind_m, dig_m, odd_pos),
                             in_if.last});
        odd_pos = in_if.last ? 1'b0 : ~odd_pos;
        acc_cnt++;
      end
      if (!in_if.valid || in_if.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_if.valid <= 1'b0;
        end else if (elem_q.size() > 0) begin
          nxt = elem_q.pop_front();
          in_if.valid <= 1'b1;
          in_if.value_bits <= nxt.bits;
          in_if.last <= nxt.last;
          if (burst_left > 0) begin
            burst_left--;
          end else if ($urandom_range(0, 9) == 0) begin
            burst_left = 150;
            gap_left = 0;
          end else begin
            burst_left = $urandom_range(0, 11);
            gap_left = $urandom_range(0, 5);
          end
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      rx_mode = RxOpen;
      mode_left = 0;
    end else begin
      if (mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        mode_left = $urandom_range(10, 120);
      end else begin
        mode_left--;
      end
      case (rx_mode)
        RxOpen:   rdy = 1'b1;
        RxHalf:   rdy = 1'($urandom_range(0, 1));
        RxSparse: rdy = ($urandom_range(0, 3) == 0);
        default:  rdy = ($urandom_range(0, 7) != 0);
      endcase
      out_if.ready <= rdy && !hold_off;
    end
  end

  // hold the receiver off once while the sender keeps pushing
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
      hold_left = 0;
      hold_done = 1'b0;
    end else if (!hold_done && hold_left == 0 && acc_cnt >= 500 && elem_q.size() > 40) begin
      hold_left = HoldCyc;
      hold_off <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left--;
      if (hold_left == 0) begin
        hold_off <= 1'b0;
        hold_done = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (groomed_q.size() == 0) begin
        report_mismatch("unexpected result", out_if.result_bits, '0);
      end else begin
        want = groomed_q.pop_front();
        if (out_if.result_bits !== want.bits)
          report_mismatch("result_bits", out_if.result_bits, want.bits);
        if (out_if.last_out !== want.last)
          report_mismatch("last_out", 64'(out_if.last_out), 64'(want.last));
      end
    end
  end

  always @(posedge clk) begin
    cyc++;
    if (cyc > CycLimit) begin
      $display("tb_float64_bit_groomer_top failed");
      $finish;
    end
  end

  initial begin : stimulus
    int i;
    int ph;
    int k;
    int act_v;
    int kind_v;
    int dig_v;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = fbg_pkg::CfgAction;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.value_bits = '0;
    in_if.last = 1'b0;
    out_if.ready = 1'b0;
    err_cnt = 0;
    cyc = 0;
    pow5_tab[0] = '0;
    pow5_tab[0][0] = 1'b1;
    for (i = 1; i <= Pow5Top; i++) pow5_tab[i] = pow5_tab[i-1] * 5;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    push_item(64'h3FF0000000000000, 1'b0);
    push_item(64'h400921FB54442D18, 1'b0);
    push_item(64'hC00921FB54442D18, 1'b0);
    push_item(64'h0000000000000000, 1'b0);
    push_item(64'h8000000000000000, 1'b1);
    push_item(64'h7FF0000000000000, 1'b0);
    push_item(64'hFFF0000000000000, 1'b0);
    push_item(64'h7FF8000000000001, 1'b0);
    push_item(64'h7FF0000000000001, 1'b1);
    wait_idle();

    write_reg(fbg_pkg::CfgAction, ActGroom);
    write_reg(fbg_pkg::CfgDigitKind, 1);
    write_reg(fbg_pkg::CfgDigits, 1);
    push_item(64'h4024000000000000, 1'b0);
    push_item(64'h4023FFFFFFFFFFFF, 1'b0);
    push_item(64'h3FB999999999999A, 1'b0);
    push_item(64'h3FB9999999999999, 1'b1);
    push_item(64'h0000000000000001, 1'b0);
    push_item(64'h000FFFFFFFFFFFFF, 1'b0);
    push_item(64'h0010000000000000, 1'b0);
    push_item(64'h7FEFFFFFFFFFFFFF, 1'b1);
    push_item(64'h7FE1CCF385EBC8A0, 1'b0);
    push_item(64'hBFF0000000000000, 1'b0);
    wait_idle();

    write_reg(fbg_pkg::CfgAction, fbg_pkg::ActPad);
    write_reg(fbg_pkg::CfgDigitKind, 0);
    write_reg(fbg_pkg::CfgDigits, 16);
    push_item(64'h3FF0000000000001, 1'b0);
    push_item(64'hFFEFFFFFFFFFFFFF, 1'b0);
    push_item(64'h5555555555555555, 1'b0);
    push_item(64'hAAAAAAAAAAAAAAAA, 1'b1);
    wait_idle();

    for (ph = 0; ph < 10; ph++) begin
      act_v = (ph < 4) ? ph : $urandom_range(0, 3);
      kind_v = (ph < 4) ? ph % 2 : $urandom_range(0, 1);
      case (ph)
        0: dig_v = -512;
        1: dig_v = 511;
        2: dig_v = 0;
        3: dig_v = -20;
        4: dig_v = 16;
        5: dig_v = 17;
        default: begin
          dig_v = $urandom_range(0, 1) ? $urandom_range(0, 40) - 20 : $urandom_range(0, 1023);
        end
      endcase
      write_reg(fbg_pkg::CfgAction, act_v);
      write_reg(fbg_pkg::CfgDigitKind, kind_v);
      write_reg(fbg_pkg::CfgDigits, dig_v);
      for (k = 0; k < 115; k++) elem_q.push_back(rand_elem());
      wait_idle();
    end

    if (err_cnt == 0) begin
      $display("tb_float64_bit_groomer_top passed");
    end else begin
      $display("tb_float64_bit_groomer_top failed");
    end
    $finish;
  end

endmodule
